// ----- design/pfrg_pkg.sv -----
// ----------------------------------------------------------------------------
// Planar fill run generator package
// Types, register indexes, reset values and edge mask tables shared by the
// command decoder and the top level.
// ----------------------------------------------------------------------------
package pfrg_pkg;

	typedef enum logic [1:0] {
		MODE_PIXEL = 2'd0,
		MODE_HSPAN = 2'd1,
		MODE_VSPAN = 2'd2,
		MODE_BOX   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SEL_LEFT  = 2'd0,
		SEL_MID   = 2'd1,
		SEL_RIGHT = 2'd2
	} desc_sel_t;

	localparam logic [2:0] CFG_BYTES_PER_ROW = 3'd0;
	localparam logic [2:0] CFG_PAGE0_BASE    = 3'd1;
	localparam logic [2:0] CFG_FILL_COLOR    = 3'd5;

	localparam logic [7:0]  BYTES_PER_ROW_RESET = 8'd80;
	localparam logic [7:0]  FILL_COLOR_RESET    = 8'd0;
	localparam logic [15:0] PAGE_BASE_RESET [4] = '{16'd0, 16'd19200, 16'd38400, 16'd57600};

	localparam logic [3:0] MASK_ALL = 4'hF;

	typedef struct packed {
		mode_t      mode;
		logic [9:0] x_left;
		logic [9:0] x_right;
		logic [8:0] y_top;
		logic [8:0] y_bottom;
		logic [1:0] page;
	} cmd_t;

	typedef struct packed {
		logic       err;
		logic       single;
		logic [3:0] mask_a;
		logic [3:0] mask_r;
		logic [7:0] span;
		logic [9:0] rows;
		logic [7:0] stride;
		logic [7:0] color;
	} job_t;

	function automatic logic [3:0] left_edge_mask(input logic [1:0] sub);
		logic [3:0] m;
		case (sub)
			2'd0: m = 4'h0F;
			2'd1: m = 4'h0E;
			2'd2: m = 4'h0C;
			2'd3: m = 4'h08;
			default: m = 4'h0F;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] right_edge_mask(input logic [1:0] sub);
		logic [3:0] m;
		case (sub)
			2'd0: m = 4'h01;
			2'd1: m = 4'h03;
			2'd2: m = 4'h07;
			2'd3: m = 4'h0F;
			default: m = 4'h0F;
		endcase
		return m;
	endfunction

endpackage

// ----- design/planar_fill_run_generator.sv -----
// ----------------------------------------------------------------------------
// Planar fill run generator
// Converts draw commands into planar write-run descriptors for a four-plane
// frame buffer: left edge, middle and right edge runs, or a single run.
// ----------------------------------------------------------------------------
// A command passes through the input register and the job register, and each of
// its descriptors then through the output register, before it reaches the output.
// Output rate: one descriptor per cycle while m_axis_tready is high; a command
// yields one to three descriptors, and the single output channel sets the rate.
// Reset clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module planar_fill_run_generator #(
	parameter int PAGE_COUNT  = 4,
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[1:0], x_left[11:2], x_right[21:12], y_top[30:22], y_bottom[39:31],
	// page[41:40], zero fill above.
	input  logic [47:0] s_axis_tdata,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// start_offset[15:0], plane_mask[19:16], run_bytes[27:20], row_count[37:28],
	// row_stride[45:38], color[53:46], zero fill above.
	output logic [55:0] m_axis_tdata,
	// bad_command
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);

	logic [7:0]  bytes_per_row_q;
	logic [7:0]  fill_color_q;
	logic [15:0] page_base_q [PAGE_COUNT];

	pfrg_pkg::cmd_t         cmd_s1;
	logic                   valid_s1;
	pfrg_pkg::job_t         job_s2;
	logic [OFFSET_BITS-1:0] start_s2;
	logic                   valid_s2;
	pfrg_pkg::desc_sel_t    sel_q;
	pfrg_pkg::desc_sel_t    sel_next;

	pfrg_pkg::job_t         job_c;
	logic [OFFSET_BITS-1:0] start_c;

	logic                   out_valid_q;
	logic [15:0]            offset_q;
	logic [3:0]             mask_q;
	logic [7:0]             run_q;
	logic [9:0]             rows_q;
	logic [7:0]             stride_q;
	logic [7:0]             color_q;
	logic                   bad_q;
	logic                   last_q;

	logic                   out_load;
	logic                   is_last;
	logic                   s2_done;
	logic                   move_s1;
	logic [OFFSET_BITS-1:0] offset_c;
	logic [3:0]             mask_c;
	logic [7:0]             run_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_row_q <= pfrg_pkg::BYTES_PER_ROW_RESET;
			fill_color_q    <= pfrg_pkg::FILL_COLOR_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == pfrg_pkg::CFG_BYTES_PER_ROW) begin
				bytes_per_row_q <= cfg_data[7:0];
			end
			if (cfg_addr == pfrg_pkg::CFG_FILL_COLOR) begin
				fill_color_q <= cfg_data[7:0];
			end
		end
	end

	for (genvar p = 0; p < PAGE_COUNT; p++) begin : g_page
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				page_base_q[p] <= pfrg_pkg::PAGE_BASE_RESET[p];
			end else if (cfg_we && cfg_addr == pfrg_pkg::CFG_PAGE0_BASE + 3'(p)) begin
				page_base_q[p] <= cfg_data;
			end
		end
	end

	assign out_load      = valid_s2 && (!out_valid_q || m_axis_tready);
	assign is_last       = job_s2.single || (sel_q == pfrg_pkg::SEL_RIGHT);
	assign s2_done       = out_load && is_last;
	assign move_s1       = valid_s1 && (!valid_s2 || s2_done);
	assign s_axis_tready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1.mode     <= pfrg_pkg::mode_t'(s_axis_tdata[1:0]);
			cmd_s1.x_left   <= s_axis_tdata[11:2];
			cmd_s1.x_right  <= s_axis_tdata[21:12];
			cmd_s1.y_top    <= s_axis_tdata[30:22];
			cmd_s1.y_bottom <= s_axis_tdata[39:31];
			cmd_s1.page     <= s_axis_tdata[41:40];
		end
	end

	pfrg_cmd_decode #(
		.PAGE_COUNT  (PAGE_COUNT),
		.OFFSET_BITS (OFFSET_BITS)
	) u_decode (
		.cmd           (cmd_s1),
		.bytes_per_row (bytes_per_row_q),
		.page_base     (page_base_q),
		.fill_color    (fill_color_q),
		.job           (job_c),
		.start         (start_c)
	);

	always_comb begin
		case (sel_q)
			pfrg_pkg::SEL_LEFT:  sel_next = (job_s2.span > 8'd1) ? pfrg_pkg::SEL_MID
				: pfrg_pkg::SEL_RIGHT;
			pfrg_pkg::SEL_MID:   sel_next = pfrg_pkg::SEL_RIGHT;
			pfrg_pkg::SEL_RIGHT: sel_next = pfrg_pkg::SEL_LEFT;
			default:             sel_next = pfrg_pkg::SEL_LEFT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			sel_q    <= pfrg_pkg::SEL_LEFT;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
			sel_q    <= pfrg_pkg::SEL_LEFT;
		end else if (out_load) begin
			valid_s2 <= !is_last;
			sel_q    <= sel_next;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			job_s2   <= job_c;
			start_s2 <= start_c;
		end
	end

	always_comb begin
		case (sel_q)
			pfrg_pkg::SEL_MID: begin
				offset_c = start_s2 + OFFSET_BITS'(1);
				mask_c   = pfrg_pkg::MASK_ALL;
				run_c    = job_s2.span - 8'd1;
			end
			pfrg_pkg::SEL_RIGHT: begin
				offset_c = start_s2 + OFFSET_BITS'(job_s2.span);
				mask_c   = job_s2.mask_r;
				run_c    = 8'd1;
			end
			default: begin
				offset_c = start_s2;
				mask_c   = job_s2.mask_a;
				run_c    = job_s2.err ? 8'd0 : 8'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			offset_q <= offset_c[15:0];
			mask_q   <= mask_c;
			run_q    <= run_c;
			rows_q   <= job_s2.rows;
			stride_q <= job_s2.stride;
			color_q  <= job_s2.color;
			bad_q    <= job_s2.err;
			last_q   <= is_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, color_q, stride_q, rows_q, run_q, mask_q, offset_q};
	assign m_axis_tuser  = bad_q;
	assign m_axis_tlast  = last_q;

`ifndef SYNTH
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("Error descriptor is not marked last.");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 56'd0)
		else $error("Error descriptor carries a nonzero payload.");

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> valid_s2)
		else $error("Job released before its last descriptor.");

	a_stall_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2)
		else $error("Input stalled with a free stage.");
`endif

endmodule

// ----- design/pfrg_cmd_decode.sv -----
// ----------------------------------------------------------------------------
// Planar fill command decoder
// Turns one draw command into a run job: start offset, edge masks, column
// span, row count and error flag.
// ----------------------------------------------------------------------------
module pfrg_cmd_decode #(
	parameter int PAGE_COUNT  = 4,
	parameter int OFFSET_BITS = 16
) (
	input  pfrg_pkg::cmd_t         cmd,
	input  logic [7:0]             bytes_per_row,
	input  logic [15:0]            page_base [PAGE_COUNT],
	input  logic [7:0]             fill_color,
	output pfrg_pkg::job_t         job,
	output logic [OFFSET_BITS-1:0] start
);

	localparam int PG_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam logic [1:0] PAGE_LAST = 2'(PAGE_COUNT - 1);

	logic [1:0]  page_c;
	logic [15:0] base;
	logic [9:0]  xr_e;
	logic [8:0]  yb_e;
	logic        is_point;
	logic        err;
	logic [7:0]  lcol;
	logic [7:0]  rcol;
	logic [3:0]  lmask;
	logic [3:0]  rmask;
	logic [3:0]  pmask;
	logic [16:0] prod;

	always_comb begin
		page_c = (cmd.page > PAGE_LAST) ? PAGE_LAST : cmd.page;
		base   = page_base[page_c[PG_W-1:0]];

		xr_e = (cmd.mode == pfrg_pkg::MODE_HSPAN || cmd.mode == pfrg_pkg::MODE_BOX)
			? cmd.x_right : cmd.x_left;
		yb_e = (cmd.mode == pfrg_pkg::MODE_VSPAN || cmd.mode == pfrg_pkg::MODE_BOX)
			? cmd.y_bottom : cmd.y_top;

		is_point = (cmd.mode == pfrg_pkg::MODE_PIXEL) || (cmd.mode == pfrg_pkg::MODE_VSPAN);
		err = (cmd.mode != pfrg_pkg::MODE_PIXEL) && ((xr_e < cmd.x_left) || (yb_e < cmd.y_top));

		lcol  = cmd.x_left[9:2];
		rcol  = xr_e[9:2];
		lmask = pfrg_pkg::left_edge_mask(cmd.x_left[1:0]);
		rmask = pfrg_pkg::right_edge_mask(xr_e[1:0]);
		pmask = 4'b0001 << cmd.x_left[1:0];
		prod  = 17'(cmd.y_top) * 17'(bytes_per_row);

		job.err    = err;
		job.single = err || is_point || (lcol == rcol);
		if (err) begin
			job.mask_a = 4'h0;
		end else if (is_point) begin
			job.mask_a = pmask;
		end else if (lcol == rcol) begin
			job.mask_a = lmask & rmask;
		end else begin
			job.mask_a = lmask;
		end
		job.mask_r = rmask;
		job.span   = rcol - lcol;
		job.rows   = err ? 10'd0 : (10'(yb_e) - 10'(cmd.y_top) + 10'd1);
		job.stride = err ? 8'd0 : bytes_per_row;
		job.color  = err ? 8'd0 : fill_color;

		start = err ? '0 : (OFFSET_BITS'(prod) + OFFSET_BITS'(lcol) + OFFSET_BITS'(base));
	end

endmodule

// ----- bench/pfrg_run_checker.sv -----
// ----------------------------------------------------------------------------
// Planar fill run checker
// Watches the register port and both stream channels of the run generator.
// Each accepted command is expanded into its expected write-run descriptors,
// and each descriptor transfer is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module pfrg_run_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          pending_runs,
	output int          error_count
);

	typedef struct packed {
		logic [15:0] offset;
		logic [3:0]  mask;
		logic [7:0]  run;
		logic [9:0]  rows;
		logic [7:0]  stride;
		logic [7:0]  color;
		logic        bad;
		logic        is_last;
	} run_desc_t;

	localparam logic [3:0] LEFT_MASKS [4]  = '{4'hF, 4'hE, 4'hC, 4'h8};
	localparam logic [3:0] RIGHT_MASKS [4] = '{4'h1, 4'h3, 4'h7, 4'hF};

	logic [7:0]  row_bytes;
	logic [15:0] page_base [4];
	logic [7:0]  fill_byte;
	run_desc_t   expected_runs [$];

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("[%0t] descriptor mismatch on %s: got 0x%0h, expected 0x%0h",
			$realtime, what, got, want);
		error_count++;
	endtask

	function automatic run_desc_t make_run(input logic [31:0] offset,
		input logic [3:0] mask, input logic [7:0] run, input logic [9:0] rows,
		input logic is_last);
		run_desc_t d;
		d.offset  = offset[15:0];
		d.mask    = mask;
		d.run     = run;
		d.rows    = rows;
		d.stride  = row_bytes;
		d.color   = fill_byte;
		d.bad     = 1'b0;
		d.is_last = is_last;
		return d;
	endfunction

	function automatic void plan_descriptors(input pfrg_pkg::mode_t mode,
		input logic [9:0] xl, input logic [9:0] xr, input logic [8:0] yt,
		input logic [8:0] yb, input logic [1:0] pg);
		logic [31:0] start;
		logic [9:0]  rows;
		logic [7:0]  lcol;
		logic [7:0]  rcol;
		logic [3:0]  lmask;
		logic [3:0]  rmask;
		run_desc_t   err;
		start = 32'(yt) * 32'(row_bytes) + 32'(xl[9:2]) + 32'(page_base[pg]);
		if (mode == pfrg_pkg::MODE_PIXEL) begin
			expected_runs.push_back(make_run(start, 4'b0001 << xl[1:0], 8'd1, 10'd1, 1'b1));
			return;
		end
		if (mode == pfrg_pkg::MODE_HSPAN) begin
			yb = yt;
		end else if (mode == pfrg_pkg::MODE_VSPAN) begin
			xr = xl;
		end
		if (xr < xl || yb < yt) begin
			err = '0;
			err.bad = 1'b1;
			err.is_last = 1'b1;
			expected_runs.push_back(err);
			return;
		end
		rows = 10'(yb) - 10'(yt) + 10'd1;
		if (mode == pfrg_pkg::MODE_VSPAN) begin
			expected_runs.push_back(make_run(start, 4'b0001 << xl[1:0], 8'd1, rows, 1'b1));
			return;
		end
		lcol  = xl[9:2];
		rcol  = xr[9:2];
		lmask = LEFT_MASKS[xl[1:0]];
		rmask = RIGHT_MASKS[xr[1:0]];
		if (lcol == rcol) begin
			expected_runs.push_back(make_run(start, lmask & rmask, 8'd1, rows, 1'b1));
			return;
		end
		expected_runs.push_back(make_run(start, lmask, 8'd1, rows, 1'b0));
		if (rcol - lcol > 8'd1) begin
			expected_runs.push_back(make_run(start + 32'd1, pfrg_pkg::MASK_ALL,
				rcol - lcol - 8'd1, rows, 1'b0));
		end
		expected_runs.push_back(make_run(start + 32'(rcol - lcol), rmask, 8'd1, rows, 1'b1));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		run_desc_t want;
		if (!arst_n) begin
			row_bytes = pfrg_pkg::BYTES_PER_ROW_RESET;
			fill_byte = pfrg_pkg::FILL_COLOR_RESET;
			for (int k = 0; k < 4; k++) begin
				page_base[k] = pfrg_pkg::PAGE_BASE_RESET[k];
			end
			expected_runs.delete();
			error_count = 0;
			pending_runs <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == pfrg_pkg::CFG_BYTES_PER_ROW) begin
					row_bytes = cfg_data[7:0];
				end else if (cfg_addr == pfrg_pkg::CFG_FILL_COLOR) begin
					fill_byte = cfg_data[7:0];
				end else if (cfg_addr >= pfrg_pkg::CFG_PAGE0_BASE
					&& cfg_addr < pfrg_pkg::CFG_PAGE0_BASE + 3'd4) begin
					page_base[2'(cfg_addr - pfrg_pkg::CFG_PAGE0_BASE)] = cfg_data;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_runs.size() == 0) begin
					report_mismatch("unexpected transfer offset", m_axis_tdata[15:0], 16'd0);
				end else begin
					want = expected_runs.pop_front();
					if (m_axis_tdata[15:0] !== want.offset)
						report_mismatch("start_offset", m_axis_tdata[15:0], want.offset);
					if (m_axis_tdata[19:16] !== want.mask)
						report_mismatch("plane_mask", 16'(m_axis_tdata[19:16]), 16'(want.mask));
					if (m_axis_tdata[27:20] !== want.run)
						report_mismatch("run_bytes", 16'(m_axis_tdata[27:20]), 16'(want.run));
					if (m_axis_tdata[37:28] !== want.rows)
						report_mismatch("row_count", 16'(m_axis_tdata[37:28]), 16'(want.rows));
					if (m_axis_tdata[45:38] !== want.stride)
						report_mismatch("row_stride", 16'(m_axis_tdata[45:38]), 16'(want.stride));
					if (m_axis_tdata[53:46] !== want.color)
						report_mismatch("color", 16'(m_axis_tdata[53:46]), 16'(want.color));
					if (m_axis_tdata[55:54] !== 2'b00)
						report_mismatch("tdata fill", 16'(m_axis_tdata[55:54]), 16'd0);
					if (m_axis_tuser !== want.bad)
						report_mismatch("bad_command", 16'(m_axis_tuser), 16'(want.bad));
					if (m_axis_tlast !== want.is_last)
						report_mismatch("last", 16'(m_axis_tlast), 16'(want.is_last));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				plan_descriptors(pfrg_pkg::mode_t'(s_axis_tdata[1:0]), s_axis_tdata[11:2],
					s_axis_tdata[21:12], s_axis_tdata[30:22], s_axis_tdata[39:31],
					s_axis_tdata[41:40]);
			end
			pending_runs <= expected_runs.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Planar fill run generator testbench
// Drives directed and random draw commands through several register settings
// with bursty input and a stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 27;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	int          pending_runs;
	int          error_count;
	int          burst_left;
	int          ready_tick = 0;
	int          ready_style = 0;
	int          cycle_count;

	always #10 clk = ~clk;

	planar_fill_run_generator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	pfrg_run_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.pending_runs  (pending_runs),
		.error_count   (error_count)
	);

	// The receiver switches between always ready, coin-flip, mostly stalled
	// and a fixed, periodic, mostly ready pattern.
	always @(posedge clk) begin
		ready_tick <= ready_tick + 1;
		if (ready_tick % 60 == 0) begin
			ready_style <= $urandom_range(0, 3);
		end
		case (ready_style)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ((ready_tick % 5) < 3);
		endcase
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_cmd(input pfrg_pkg::mode_t mode, input int xl, input int xr,
		input int yt, input int yb, input int pg);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, 2'(pg), 9'(yb), 9'(yt), 10'(xr), 10'(xl), mode};
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		if (burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic send_random_cmd();
		pfrg_pkg::mode_t mode;
		int    xl;
		int    xr;
		int    yt;
		int    yb;
		int    w;
		int    h;
		mode = pfrg_pkg::mode_t'($urandom_range(0, 3));
		xl = $urandom_range(0, 1023);
		yt = $urandom_range(0, 511);
		w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
		h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 6);
		xr = (xl + w > 1023) ? 1023 : xl + w;
		yb = (yt + h > 511) ? 511 : yt + h;
		if (mode == pfrg_pkg::MODE_PIXEL) begin
			xr = $urandom_range(0, 1023);
			yb = $urandom_range(0, 511);
		end else if ($urandom_range(0, 7) == 0) begin
			if (xl > 0 && $urandom_range(0, 1) == 1) begin
				xr = $urandom_range(0, xl - 1);
			end
			if (yt > 0 && $urandom_range(0, 1) == 1) begin
				yb = $urandom_range(0, yt - 1);
			end
		end
		send_cmd(mode, xl, xr, yt, yb, $urandom_range(0, 3));
	endtask

	task automatic run_directed();
		send_cmd(pfrg_pkg::MODE_PIXEL, 0, 0, 0, 0, 0);
		send_cmd(pfrg_pkg::MODE_PIXEL, 1023, 0, 511, 0, 3);
		send_cmd(pfrg_pkg::MODE_PIXEL, 5, 1023, 7, 511, 1);
		send_cmd(pfrg_pkg::MODE_PIXEL, 514, 3, 100, 2, 2);
		send_cmd(pfrg_pkg::MODE_HSPAN, 0, 1023, 0, 0, 0);
		send_cmd(pfrg_pkg::MODE_HSPAN, 5, 6, 10, 0, 1);
		send_cmd(pfrg_pkg::MODE_HSPAN, 3, 4, 20, 0, 2);
		send_cmd(pfrg_pkg::MODE_HSPAN, 9, 8, 30, 0, 3);
		send_cmd(pfrg_pkg::MODE_HSPAN, 7, 7, 511, 0, 0);
		send_cmd(pfrg_pkg::MODE_HSPAN, 1, 1022, 0, 0, 2);
		send_cmd(pfrg_pkg::MODE_VSPAN, 1023, 0, 0, 511, 3);
		send_cmd(pfrg_pkg::MODE_VSPAN, 2, 0, 40, 40, 1);
		send_cmd(pfrg_pkg::MODE_VSPAN, 2, 0, 41, 40, 2);
		send_cmd(pfrg_pkg::MODE_BOX, 0, 1023, 0, 511, 0);
		send_cmd(pfrg_pkg::MODE_BOX, 1, 2, 5, 9, 1);
		send_cmd(pfrg_pkg::MODE_BOX, 6, 13, 100, 103, 2);
		send_cmd(pfrg_pkg::MODE_BOX, 20, 19, 5, 6, 3);
		send_cmd(pfrg_pkg::MODE_BOX, 20, 30, 7, 6, 0);
		send_cmd(pfrg_pkg::MODE_BOX, 30, 20, 9, 3, 1);
		send_cmd(pfrg_pkg::MODE_BOX, 1020, 1023, 500, 511, 3);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_runs != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
		cfg_we   <= 1'b1;
		cfg_addr <= index;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic program_regs(input int row_bytes, input int base0, input int base1,
		input int base2, input int base3, input int color);
		write_reg(pfrg_pkg::CFG_BYTES_PER_ROW, 16'(row_bytes));
		write_reg(pfrg_pkg::CFG_PAGE0_BASE, 16'(base0));
		write_reg(pfrg_pkg::CFG_PAGE0_BASE + 3'd1, 16'(base1));
		write_reg(pfrg_pkg::CFG_PAGE0_BASE + 3'd2, 16'(base2));
		write_reg(pfrg_pkg::CFG_PAGE0_BASE + 3'd3, 16'(base3));
		write_reg(pfrg_pkg::CFG_FILL_COLOR, 16'(color));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		burst_left = $urandom_range(1, 8);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		repeat (RANDOM_PER_PHASE) send_random_cmd();

		for (int phase = 1; phase <= 6; phase++) begin
			wait_idle();
			case (phase)
				1: program_regs(255, 65535, 65535, 65535, 65535, 255);
				2: program_regs(1, 0, 0, 0, 0, 0);
				3: program_regs(0, $urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 255));
				4: program_regs(80, 0, 19200, 38400, 57600, 8'hA5);
				default: program_regs($urandom_range(1, 255), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 255));
			endcase
			if (phase == 1) begin
				run_directed();
			end
			repeat (RANDOM_PER_PHASE) send_random_cmd();
		end

		wait_idle();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
